// ===== design/spi_pkg.sv =====
// Shared types and constants for the segment pair intersection block.
// Holds the input and result beat structs and small helper functions.
// No dependencies.
package spi_pkg;

	localparam int COORD_BITS = 16;
	localparam int OUT_BITS   = 24;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t first_start_x;
		coord_t first_start_y;
		coord_t first_end_x;
		coord_t first_end_y;
		coord_t second_start_x;
		coord_t second_start_y;
		coord_t second_end_x;
		coord_t second_end_y;
	} seg_pair_t;

	typedef struct packed {
		logic                       segments_meet;
		logic                       point_valid;
		logic signed [OUT_BITS-1:0] cross_x;
		logic signed [OUT_BITS-1:0] cross_y;
	} result_t;

	// Flags that ride along with the divider lanes.
	typedef struct packed {
		logic meet;
		logic point_valid;
		logic neg_x;
		logic neg_y;
	} side_t;

	// Point k lies inside the inclusive bounding box of corners i and j.
	function automatic logic in_box(input coord_t ix, input coord_t iy,
			input coord_t jx, input coord_t jy, input coord_t kx, input coord_t ky);
		coord_t lx;
		coord_t hx;
		coord_t ly;
		coord_t hy;
		lx = (ix < jx) ? ix : jx;
		hx = (ix < jx) ? jx : ix;
		ly = (iy < jy) ? iy : jy;
		hy = (iy < jy) ? jy : iy;
		return (lx <= kx) && (kx <= hx) && (ly <= ky) && (ky <= hy);
	endfunction

	// Clamp a quotient magnitude to the signed output range and apply the sign.
	function automatic logic signed [OUT_BITS-1:0] saturate(input logic [OUT_BITS-1:0] q,
			input logic ovf, input logic neg);
		logic [OUT_BITS-1:0] lim;
		logic [OUT_BITS-1:0] mag;
		lim = neg ? (OUT_BITS'(1) << (OUT_BITS - 1))
		          : ((OUT_BITS'(1) << (OUT_BITS - 1)) - OUT_BITS'(1));
		mag = (ovf || (q > lim)) ? lim : q;
		return neg ? $signed(-mag) : $signed(mag);
	endfunction

endpackage

// ===== design/spi_div.sv =====
// Pipelined restoring divider with two lanes sharing one divisor.
// One quotient bit per stage plus an overflow check stage; uses spi_pkg.
// Carries the beat valid bit and side flags alongside the data.
module spi_div #(
	parameter int NW = 59,
	parameter int DW = 35
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  spi_pkg::side_t                in_side,
	input  logic [NW-1:0]                 num_x,
	input  logic [NW-1:0]                 num_y,
	input  logic [DW-1:0]                 den,
	output logic                          out_valid,
	output spi_pkg::side_t                out_side,
	output logic [spi_pkg::OUT_BITS-1:0]  quot_x,
	output logic [spi_pkg::OUT_BITS-1:0]  quot_y,
	output logic                          ovf_x,
	output logic                          ovf_y
);

	localparam int OB = spi_pkg::OUT_BITS;
	localparam int RW = (NW > DW + OB) ? NW : DW + OB;

	logic                 v_s    [0:OB];
	spi_pkg::side_t       side_s [0:OB];
	logic [RW-1:0]        rx_s   [0:OB];
	logic [RW-1:0]        ry_s   [0:OB];
	logic [DW-1:0]        d_s    [0:OB];
	logic [OB-1:0]        qx_s   [0:OB];
	logic [OB-1:0]        qy_s   [0:OB];
	logic                 ox_s   [0:OB];
	logic                 oy_s   [0:OB];

	logic [RW-1:0] dfull;
	assign dfull = RW'(den) << OB;

	// First stage: the quotient cannot fit when the dividend reaches den * 2^OB.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			rx_s[0]   <= RW'(num_x);
			ry_s[0]   <= RW'(num_y);
			d_s[0]    <= den;
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
			ox_s[0]   <= RW'(num_x) >= dfull;
			oy_s[0]   <= RW'(num_y) >= dfull;
		end
	end

	for (genvar j = 1; j <= OB; j++) begin : g_step
		logic [RW-1:0] trial;
		logic          ge_x;
		logic          ge_y;

		assign trial = RW'(d_s[j-1]) << (OB - j);
		assign ge_x  = rx_s[j-1] >= trial;
		assign ge_y  = ry_s[j-1] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[j] <= side_s[j-1];
				d_s[j]    <= d_s[j-1];
				ox_s[j]   <= ox_s[j-1];
				oy_s[j]   <= oy_s[j-1];
				rx_s[j]   <= ge_x ? rx_s[j-1] - trial : rx_s[j-1];
				ry_s[j]   <= ge_y ? ry_s[j-1] - trial : ry_s[j-1];
				qx_s[j]   <= qx_s[j-1] | (OB'(ge_x) << (OB - j));
				qy_s[j]   <= qy_s[j-1] | (OB'(ge_y) << (OB - j));
			end
		end
	end

	assign out_valid = v_s[OB];
	assign out_side  = side_s[OB];
	assign quot_x    = qx_s[OB];
	assign quot_y    = qy_s[OB];
	assign ovf_x     = ox_s[OB];
	assign ovf_y     = oy_s[OB];

endmodule

// ===== design/segment_pair_intersection.sv =====
// Top level of the segment pair intersection block.
// Depends on spi_pkg (beat types, helpers) and spi_div (quotient pipeline).
//
//  channel | valid     | stall     | payload             | direction
//  --------+-----------+-----------+---------------------+----------
//  segment | seg_valid | seg_stall | seg (seg_pair_t)    | in
//  result  | res_valid | res_stall | res (result_t)      | out
//
// A new segment pair can enter on every clock cycle in which seg_stall is low;
// each one yields exactly one result beat. Most of the pipeline depth comes
// from the divider, which resolves one quotient bit per stage. Reset clears
// only the valid bits of the pipeline. A stall on the result channel while a
// result is held freezes every stage at once and is passed straight back as
// seg_stall, so no beat is dropped or repeated.
module segment_pair_intersection #(
	parameter int FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seg_valid,
	output logic               seg_stall,
	input  spi_pkg::seg_pair_t seg,
	output logic               res_valid,
	input  logic               res_stall,
	output spi_pkg::result_t   res
);

	localparam int C    = spi_pkg::COORD_BITS;
	localparam int DFW  = C + 1;          // coordinate difference
	localparam int PW   = 2 * C + 2;      // product of two differences
	localparam int OW   = 2 * C + 3;      // orientation value and determinant
	localparam int CPW  = 2 * C;          // product of two coordinates
	localparam int CW   = 2 * C + 1;      // line constant
	localparam int NPW  = CW + DFW;       // numerator partial product
	localparam int NUMW = NPW + 1;        // numerator
	localparam int NMAG = NUMW + FRAC_BITS;

	// The whole pipeline advances together unless a held result is stalled.
	logic en;
	assign en        = !(res_valid && res_stall);
	assign seg_stall = !en;

	// ------------------------------------------------------------------
	// Stage 1: coordinate differences and the bounding box tests.
	// ------------------------------------------------------------------
	spi_pkg::coord_t x1, y1, x2, y2, x3, y3, x4, y4;
	assign x1 = seg.first_start_x;
	assign y1 = seg.first_start_y;
	assign x2 = seg.first_end_x;
	assign y2 = seg.first_end_y;
	assign x3 = seg.second_start_x;
	assign y3 = seg.second_start_y;
	assign x4 = seg.second_end_x;
	assign y4 = seg.second_end_y;

	logic v_s1;
	logic signed [DFW-1:0] dx12_s1, dy12_s1, dx34_s1, dy34_s1;
	logic signed [DFW-1:0] ay43_s1, ax43_s1, bx14_s1, by14_s1, bx24_s1, by24_s1;
	logic signed [DFW-1:0] ay21_s1, ax21_s1, cx32_s1, cy32_s1, cx42_s1, cy42_s1;
	spi_pkg::coord_t x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, x4_s1, y4_s1;
	logic [3:0] box_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= seg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx12_s1 <= DFW'(x1) - DFW'(x2);
			dy12_s1 <= DFW'(y1) - DFW'(y2);
			dx34_s1 <= DFW'(x3) - DFW'(x4);
			dy34_s1 <= DFW'(y3) - DFW'(y4);
			ay43_s1 <= DFW'(y4) - DFW'(y3);
			ax43_s1 <= DFW'(x4) - DFW'(x3);
			bx14_s1 <= DFW'(x1) - DFW'(x4);
			by14_s1 <= DFW'(y1) - DFW'(y4);
			bx24_s1 <= DFW'(x2) - DFW'(x4);
			by24_s1 <= DFW'(y2) - DFW'(y4);
			ay21_s1 <= DFW'(y2) - DFW'(y1);
			ax21_s1 <= DFW'(x2) - DFW'(x1);
			cx32_s1 <= DFW'(x3) - DFW'(x2);
			cy32_s1 <= DFW'(y3) - DFW'(y2);
			cx42_s1 <= DFW'(x4) - DFW'(x2);
			cy42_s1 <= DFW'(y4) - DFW'(y2);
			x1_s1 <= x1;
			y1_s1 <= y1;
			x2_s1 <= x2;
			y2_s1 <= y2;
			x3_s1 <= x3;
			y3_s1 <= y3;
			x4_s1 <= x4;
			y4_s1 <= y4;
			box_s1[0] <= spi_pkg::in_box(x3, y3, x4, y4, x1, y1);
			box_s1[1] <= spi_pkg::in_box(x3, y3, x4, y4, x2, y2);
			box_s1[2] <= spi_pkg::in_box(x1, y1, x2, y2, x3, y3);
			box_s1[3] <= spi_pkg::in_box(x1, y1, x2, y2, x4, y4);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: all first level products, one multiplier each.
	// ------------------------------------------------------------------
	logic v_s2;
	logic signed [PW-1:0]  o1a_s2, o1b_s2, o2a_s2, o2b_s2;
	logic signed [PW-1:0]  o3a_s2, o3b_s2, o4a_s2, o4b_s2;
	logic signed [PW-1:0]  deta_s2, detb_s2;
	logic signed [CPW-1:0] c1a_s2, c1b_s2, c2a_s2, c2b_s2;
	logic signed [DFW-1:0] dx12_s2, dy12_s2, dx34_s2, dy34_s2;
	logic [3:0] box_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o1a_s2  <= ay43_s1 * bx14_s1;
			o1b_s2  <= ax43_s1 * by14_s1;
			o2a_s2  <= ay43_s1 * bx24_s1;
			o2b_s2  <= ax43_s1 * by24_s1;
			o3a_s2  <= ay21_s1 * cx32_s1;
			o3b_s2  <= ax21_s1 * cy32_s1;
			o4a_s2  <= ay21_s1 * cx42_s1;
			o4b_s2  <= ax21_s1 * cy42_s1;
			deta_s2 <= dx12_s1 * dy34_s1;
			detb_s2 <= dy12_s1 * dx34_s1;
			c1a_s2  <= x1_s1 * y2_s1;
			c1b_s2  <= x2_s1 * y1_s1;
			c2a_s2  <= x3_s1 * y4_s1;
			c2b_s2  <= x4_s1 * y3_s1;
			dx12_s2 <= dx12_s1;
			dy12_s2 <= dy12_s1;
			dx34_s2 <= dx34_s1;
			dy34_s2 <= dy34_s1;
			box_s2  <= box_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: orientation signs, determinant and line constants.
	// ------------------------------------------------------------------
	logic signed [OW-1:0] ori [0:3];
	assign ori[0] = OW'(o1a_s2) - OW'(o1b_s2);
	assign ori[1] = OW'(o2a_s2) - OW'(o2b_s2);
	assign ori[2] = OW'(o3a_s2) - OW'(o3b_s2);
	assign ori[3] = OW'(o4a_s2) - OW'(o4b_s2);

	logic v_s3;
	logic [3:0] neg_s3, zero_s3, box_s3;
	logic signed [OW-1:0]  det_s3;
	logic signed [CW-1:0]  c1_s3, c2_s3;
	logic signed [DFW-1:0] dx12_s3, dy12_s3, dx34_s3, dy34_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				neg_s3[i]  <= ori[i][OW-1];
				zero_s3[i] <= ori[i] == '0;
			end
			det_s3  <= OW'(deta_s2) - OW'(detb_s2);
			c1_s3   <= CW'(c1a_s2) - CW'(c1b_s2);
			c2_s3   <= CW'(c2a_s2) - CW'(c2b_s2);
			dx12_s3 <= dx12_s2;
			dy12_s3 <= dy12_s2;
			dx34_s3 <= dx34_s2;
			dy34_s3 <= dy34_s2;
			box_s3  <= box_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: meet decision and the numerator products.
	// ------------------------------------------------------------------
	// A proper crossing needs each pair of orientations nonzero and opposite.
	logic cross_ab, cross_cd, meet;
	assign cross_ab = !zero_s3[0] && !zero_s3[1] && (neg_s3[0] != neg_s3[1]);
	assign cross_cd = !zero_s3[2] && !zero_s3[3] && (neg_s3[2] != neg_s3[3]);
	assign meet     = (cross_ab && cross_cd) || |(zero_s3 & box_s3);

	logic v_s4, meet_s4;
	logic signed [OW-1:0]  det_s4;
	logic signed [NPW-1:0] nxa_s4, nxb_s4, nya_s4, nyb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meet_s4 <= meet;
			det_s4  <= det_s3;
			nxa_s4  <= c1_s3 * dx34_s3;
			nxb_s4  <= c2_s3 * dx12_s3;
			nya_s4  <= c1_s3 * dy34_s3;
			nyb_s4  <= c2_s3 * dy12_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: numerators and the determinant zero flag.
	// ------------------------------------------------------------------
	logic v_s5, meet_s5, pv_s5;
	logic signed [OW-1:0]   det_s5;
	logic signed [NUMW-1:0] nx_s5, ny_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meet_s5 <= meet_s4;
			pv_s5   <= det_s4 != '0;
			det_s5  <= det_s4;
			nx_s5   <= NUMW'(nxa_s4) - NUMW'(nxb_s4);
			ny_s5   <= NUMW'(nya_s4) - NUMW'(nyb_s4);
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: magnitudes, quotient signs and the fraction scaling.
	// ------------------------------------------------------------------
	logic [NUMW-1:0] nxm, nym;
	logic [OW-1:0]   detm;
	assign nxm  = nx_s5[NUMW-1] ? NUMW'(-nx_s5) : NUMW'(nx_s5);
	assign nym  = ny_s5[NUMW-1] ? NUMW'(-ny_s5) : NUMW'(ny_s5);
	assign detm = det_s5[OW-1] ? OW'(-det_s5) : OW'(det_s5);

	logic v_s6;
	spi_pkg::side_t  side_s6;
	logic [NMAG-1:0] nx_s6, ny_s6;
	logic [OW-1:0]   det_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6.meet        <= meet_s5;
			side_s6.point_valid <= pv_s5;
			side_s6.neg_x       <= nx_s5[NUMW-1] != det_s5[OW-1];
			side_s6.neg_y       <= ny_s5[NUMW-1] != det_s5[OW-1];
			nx_s6  <= NMAG'(nxm) << FRAC_BITS;
			ny_s6  <= NMAG'(nym) << FRAC_BITS;
			det_s6 <= detm;
		end
	end

	// ------------------------------------------------------------------
	// Divider: one quotient bit per stage for both coordinates.
	// ------------------------------------------------------------------
	logic                         dv;
	spi_pkg::side_t               dside;
	logic [spi_pkg::OUT_BITS-1:0] qx, qy;
	logic                         ovx, ovy;

	spi_div #(
		.NW (NMAG),
		.DW (OW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.in_side   (side_s6),
		.num_x     (nx_s6),
		.num_y     (ny_s6),
		.den       (det_s6),
		.out_valid (dv),
		.out_side  (dside),
		.quot_x    (qx),
		.quot_y    (qy),
		.ovf_x     (ovx),
		.ovf_y     (ovy)
	);

	// ------------------------------------------------------------------
	// Output register: saturation, sign, and zeroing for parallel lines.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.segments_meet <= dside.meet;
			res.point_valid   <= dside.point_valid;
			res.cross_x       <= dside.point_valid ?
				spi_pkg::saturate(qx, ovx, dside.neg_x) : '0;
			res.cross_y       <= dside.point_valid ?
				spi_pkg::saturate(qy, ovy, dside.neg_y) : '0;
		end
	end

endmodule

// ===== sim/segment_pair_intersection_tb.sv =====
// Self-checking testbench for segment_pair_intersection.
// Depends on spi_pkg and the RTL under design/. It takes each expected result from the
// directed table or from its own integer model, and drives directed pairs followed by random pairs.
`timescale 1ns / 100ps

module segment_pair_intersection_tb;

	localparam int    OUT_W  = spi_pkg::OUT_BITS;
	localparam int    FRAC   = 8;
	localparam int    LATENCY = 6 + OUT_W + 2;
	localparam int    N_RANDOM = 540;
	localparam int    QUIET_FROM = 440;  // random pairs from this index on run without idling
	localparam int    HOLD_AT = 150;     // random pair index that triggers the long result hold
	localparam int    DRAIN_AT = 320;    // random pair index before which the sender drains
	localparam int    STALL_LIMIT = 4000;

	logic               clk;
	logic               arst_n;
	logic               seg_valid;
	logic               seg_stall;
	spi_pkg::seg_pair_t seg;
	logic               res_valid;
	logic               res_stall;
	spi_pkg::result_t   res;

	// One row of the directed table. When typed is set, want holds the result
	// read straight off the rules; otherwise the predictor supplies it.
	typedef struct {
		spi_pkg::seg_pair_t pair;
		bit                 typed;
		spi_pkg::result_t   want;
	} row_t;

	spi_pkg::result_t pending_results[$];
	row_t             rows[$];
	int               errors;
	int               results_seen;
	int               meets_seen;
	int               points_seen;
	int               saturated_seen;
	int               quiet_cycles;
	bit               long_hold_req;
	bit               quiet;

	segment_pair_intersection u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#6 clk = ~clk;
		end
	end

	// Sign of the orientation cross product (k - j) x (j - i).
	function automatic int orient_sign(longint ix, longint iy, longint jx, longint jy,
			longint kx, longint ky);
		longint t;
		t = (jy - iy) * (kx - jx) - (jx - ix) * (ky - jy);
		return (t < 0) ? -1 : ((t == 0) ? 0 : 1);
	endfunction

	// Point k inside the inclusive bounding box spanned by i and j.
	function automatic bit box_holds(longint ix, longint iy, longint jx, longint jy,
			longint kx, longint ky);
		longint lx;
		longint hx;
		longint ly;
		longint hy;
		lx = (ix < jx) ? ix : jx;
		hx = (ix < jx) ? jx : ix;
		ly = (iy < jy) ? iy : jy;
		hy = (iy < jy) ? jy : iy;
		return (lx <= kx) && (kx <= hx) && (ly <= ky) && (ky <= hy);
	endfunction

	// num * 2^FRAC / den, truncated toward zero and clamped to the output range.
	// The magnitudes here stay below 2^51, so 64 bits hold the scaled numerator.
	function automatic logic signed [OUT_W-1:0] fixed_coord(longint num, longint den);
		bit                  neg;
		longint unsigned     n;
		longint unsigned     d;
		longint unsigned     q;
		longint unsigned     lim;
		logic [OUT_W-1:0]    mag;
		neg = (num < 0) != (den < 0);
		n   = (num < 0) ? -num : num;
		d   = (den < 0) ? -den : den;
		q   = (n << FRAC) / d;
		lim = neg ? (64'd1 << (OUT_W - 1)) : ((64'd1 << (OUT_W - 1)) - 1);
		if (q > lim) begin
			q = lim;
		end
		mag = q[OUT_W-1:0];
		return neg ? $signed(-mag) : $signed(mag);
	endfunction

	function automatic spi_pkg::result_t intersect_pair(spi_pkg::seg_pair_t p);
		longint           x1;
		longint           y1;
		longint           x2;
		longint           y2;
		longint           x3;
		longint           y3;
		longint           x4;
		longint           y4;
		int               d1;
		int               d2;
		int               d3;
		int               d4;
		longint           det;
		longint           c1;
		longint           c2;
		spi_pkg::result_t r;
		x1 = p.first_start_x;  y1 = p.first_start_y;
		x2 = p.first_end_x;    y2 = p.first_end_y;
		x3 = p.second_start_x; y3 = p.second_start_y;
		x4 = p.second_end_x;   y4 = p.second_end_y;
		d1 = orient_sign(x3, y3, x4, y4, x1, y1);
		d2 = orient_sign(x3, y3, x4, y4, x2, y2);
		d3 = orient_sign(x1, y1, x2, y2, x3, y3);
		d4 = orient_sign(x1, y1, x2, y2, x4, y4);
		r.segments_meet = (d1 * d2 < 0 && d3 * d4 < 0)
			|| (d1 == 0 && box_holds(x3, y3, x4, y4, x1, y1))
			|| (d2 == 0 && box_holds(x3, y3, x4, y4, x2, y2))
			|| (d3 == 0 && box_holds(x1, y1, x2, y2, x3, y3))
			|| (d4 == 0 && box_holds(x1, y1, x2, y2, x4, y4));
		det = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
		c1  = x1 * y2 - x2 * y1;
		c2  = x3 * y4 - x4 * y3;
		if (det == 0) begin
			r.point_valid = 1'b0;
			r.cross_x     = '0;
			r.cross_y     = '0;
		end else begin
			r.point_valid = 1'b1;
			r.cross_x     = fixed_coord(c1 * (x3 - x4) - c2 * (x1 - x2), det);
			r.cross_y     = fixed_coord(c1 * (y3 - y4) - c2 * (y1 - y2), det);
		end
		return r;
	endfunction

	function automatic spi_pkg::seg_pair_t make_pair(int ax, int ay, int bx, int by,
			int cx, int cy, int dx, int dy);
		spi_pkg::seg_pair_t p;
		p.first_start_x  = spi_pkg::coord_t'(ax);
		p.first_start_y  = spi_pkg::coord_t'(ay);
		p.first_end_x    = spi_pkg::coord_t'(bx);
		p.first_end_y    = spi_pkg::coord_t'(by);
		p.second_start_x = spi_pkg::coord_t'(cx);
		p.second_start_y = spi_pkg::coord_t'(cy);
		p.second_end_x   = spi_pkg::coord_t'(dx);
		p.second_end_y   = spi_pkg::coord_t'(dy);
		return p;
	endfunction

	function automatic spi_pkg::result_t make_result(bit meet, bit pv, int cx, int cy);
		spi_pkg::result_t r;
		r.segments_meet = meet;
		r.point_valid   = pv;
		r.cross_x       = OUT_W'(cx);
		r.cross_y       = OUT_W'(cy);
		return r;
	endfunction

	task automatic add_row(spi_pkg::seg_pair_t p, bit typed, spi_pkg::result_t want);
		row_t r;
		r.pair  = p;
		r.typed = typed;
		r.want  = want;
		rows.insert(rows.size(), r);
	endtask

	// Queue the expected result of the next beat behind those already waiting.
	task automatic expect_result(spi_pkg::result_t want);
		pending_results.insert(pending_results.size(), want);
	endtask

	task automatic report(string field, int want, int got);
		$display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
		errors++;
	endtask

	// Offer one beat and hold it until the block takes it. Called at a falling edge
	// and returns at the falling edge after acceptance, with valid still high.
	task automatic offer_pair(spi_pkg::seg_pair_t p);
		seg       <= p;
		seg_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (seg_stall);
		@(negedge clk);
	endtask

	task automatic sender_gap(int cycles);
		seg_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Random pairs: full-range, small-range (many touches and parallels),
	// parallel or collinear copies, and pairs sharing an endpoint.
	function automatic spi_pkg::seg_pair_t random_pair();
		spi_pkg::seg_pair_t p;
		int                 kind;
		int                 sx;
		int                 sy;
		kind = $urandom_range(0, 9);
		p = spi_pkg::seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
		if (kind >= 4 && kind <= 7) begin
			p = make_pair($urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
				$urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
				$urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
				$urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20);
		end else if (kind == 8) begin
			p = make_pair($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
				$urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000, 0, 0, 0, 0);
			sx = $urandom_range(0, 20) - 10;
			sy = $urandom_range(0, 20) - 10;
			p.second_start_x = p.first_start_x + spi_pkg::coord_t'(sx);
			p.second_start_y = p.first_start_y + spi_pkg::coord_t'(sy);
			p.second_end_x   = p.first_end_x + spi_pkg::coord_t'(sx);
			p.second_end_y   = p.first_end_y + spi_pkg::coord_t'(sy);
		end else if (kind == 9) begin
			p.second_start_x = p.first_end_x;
			p.second_start_y = p.first_end_y;
		end
		return p;
	endfunction

	// Monitor: count idle cycles and check accepted results against the queued predictions.
	always @(posedge clk) begin
		spi_pkg::result_t want;
		if (arst_n) begin
			if ((seg_valid && !seg_stall) || (res_valid && !res_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (res_valid && !res_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					report("unexpected result beat", 0, 1);
				end else begin
					want = pending_results.pop_front();
					if (res.segments_meet !== want.segments_meet) begin
						report("segments_meet", want.segments_meet, res.segments_meet);
					end
					if (res.point_valid !== want.point_valid) begin
						report("point_valid", want.point_valid, res.point_valid);
					end
					if (res.cross_x !== want.cross_x) begin
						report("cross_x", want.cross_x, res.cross_x);
					end
					if (res.cross_y !== want.cross_y) begin
						report("cross_y", want.cross_y, res.cross_y);
					end
					meets_seen  += want.segments_meet;
					points_seen += want.point_valid;
					if (want.point_valid && (want.cross_x == 24'sh7fffff
							|| want.cross_x == -24'sh800000)) begin
						saturated_seen++;
					end
				end
			end
		end
	end

	// Result side: random stall bursts, one long hold on request, none at the end.
	initial begin
		int burst;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				res_stall <= 1'b1;
				repeat (LATENCY * 8) @(negedge clk);
				long_hold_req = 1'b0;
				res_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 19);
				res_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				res_stall <= 1'b0;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Watchdog: too long without any beat moving means the block is stuck.
	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
		end
		$display("Timeout after %0d cycles with no beat accepted", STALL_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	// Stimulus and end of run.
	initial begin
		spi_pkg::seg_pair_t p;
		errors         = 0;
		results_seen   = 0;
		meets_seen     = 0;
		points_seen    = 0;
		saturated_seen = 0;
		long_hold_req  = 1'b0;
		quiet          = 1'b0;
		seg_valid      = 1'b0;
		seg            = '0;
		arst_n         = 1'b0;

		// Directed table.
		add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, make_result(1, 0, 0, 0));
		add_row(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
			1, make_result(1, 0, 0, 0));
		add_row(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
			1, make_result(1, 0, 0, 0));
		// Parallel lines, and collinear overlapping and disjoint segments.
		add_row(make_pair(0, 0, 10, 0, 0, 5, 10, 5), 1, make_result(0, 0, 0, 0));
		add_row(make_pair(0, 0, 10, 0, 5, 0, 20, 0), 1, make_result(1, 0, 0, 0));
		add_row(make_pair(0, 0, 10, 0, 11, 0, 20, 0), 1, make_result(0, 0, 0, 0));
		// Shared endpoint and a T junction.
		add_row(make_pair(0, 0, 10, 10, 10, 10, 20, 0), 1, make_result(1, 1, 2560, 2560));
		add_row(make_pair(0, 0, 10, 0, 5, 0, 5, 10), 1, make_result(1, 1, 1280, 0));
		// Line crossing far outside the output range, both signs.
		add_row(make_pair(0, 0, 32767, 1, 0, 2, 32767, 2), 1,
			make_result(0, 1, 8388607, 512));
		add_row(make_pair(0, 0, -32767, 1, 0, 2, -32767, 2), 1,
			make_result(0, 1, -8388608, 512));
		// A single point lying on the other segment, and one lying off it.
		add_row(make_pair(5, 5, 5, 5, 0, 0, 10, 10), 1, make_result(1, 0, 0, 0));
		add_row(make_pair(5, 6, 5, 6, 0, 0, 10, 10), 1, make_result(0, 0, 0, 0));
		// Full-scale diagonals, a near miss, and fractional crossings of both signs.
		add_row(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768),
			0, '0);
		add_row(make_pair(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768),
			0, '0);
		add_row(make_pair(0, 0, 1, 1, 5, 0, 6, -1), 0, '0);
		add_row(make_pair(0, 0, 3, 1, 0, 1, 1, 0), 0, '0);
		add_row(make_pair(0, 0, -3, -1, 0, -1, -1, 0), 0, '0);
		add_row(make_pair(-7, 3, 5, -2, 1, 9, -1, -8), 0, '0);
		add_row(make_pair(32767, -32768, -32768, 32767, 0, 0, 1, 1), 0, '0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			expect_result(rows[i].typed ? rows[i].want : intersect_pair(rows[i].pair));
			offer_pair(rows[i].pair);
			if ($urandom_range(0, 3) == 0) begin
				sender_gap($urandom_range(1, 19));
			end
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == HOLD_AT) begin
				long_hold_req = 1'b1;
			end
			if (i == DRAIN_AT) begin
				// Let every outstanding result come back before going on.
				seg_valid <= 1'b0;
				while (pending_results.size() != 0) begin
					@(negedge clk);
				end
			end
			if (i == QUIET_FROM) begin
				quiet = 1'b1;
			end
			p = random_pair();
			expect_result(intersect_pair(p));
			offer_pair(p);
			if (!quiet && $urandom_range(0, 4) == 0) begin
				sender_gap($urandom_range(1, 19));
			end
		end
		seg_valid <= 1'b0;

		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 8) @(posedge clk);

		$display("Checked %0d results: %0d meeting pairs, %0d defined crossings, %0d clamped.",
			results_seen, meets_seen, points_seen, saturated_seen);
		$display("Traffic included random stalls, one long output hold and one full drain.");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/spi_pkg.sv
design/spi_div.sv
design/segment_pair_intersection.sv
sim/segment_pair_intersection_tb.sv
